>>> rtl/psc_pkg.sv
// Package for the per-flow sequence checker: shared widths, codes, transaction
// and status structs, and the wrap-safe deadline compare.
// Depends on nothing.
`default_nettype none

package psc_pkg;

   localparam int FLOW_W     = 8;
   localparam int SEQ_W      = 32;
   localparam int TIME_W     = 32;
   localparam int WAIT_W     = 24;
   localparam int IDX_MAX_W  = 16;

   localparam logic ACT_MESSAGE = 1'b0;
   localparam logic ACT_TICK    = 1'b1;

   localparam logic [WAIT_W-1:0] WAIT_RESET  = 24'd120;
   localparam logic [SEQ_W-1:0]  SEQ_UNKNOWN = {SEQ_W{1'b1}};

   typedef struct packed {
      logic [IDX_MAX_W-1:0] idx;
      logic                 has_seq;
      logic [SEQ_W-1:0]     seq;
      logic                 cause_reset;
      logic [TIME_W-1:0]    now;
      logic [TIME_W-1:0]    new_deadline;
   } msg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qst_type;

   typedef struct packed {
      logic clearing;
   } eng_status_type;

   function automatic logic deadline_ahead(input logic [TIME_W-1:0] deadline,
                                           input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] diff;
      diff = deadline - now;
      return (diff != '0) && !diff[TIME_W-1];
   endfunction

endpackage

`default_nettype wire

>>> rtl/psc_front.sv
// Front end of the sequence checker: input handshake, flow index reduction,
// tick clock and time tagging of message transactions. Uses psc_pkg.
`default_nettype none

module psc_front
   import psc_pkg::*;
#(
   parameter int FLOWS = 256
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_action,
   input  wire logic [FLOW_W-1:0]        req_flow,
   input  wire logic                     req_has_seq,
   input  wire logic [SEQ_W-1:0]         req_seq,
   input  wire logic                     req_cause_reset,
   input  wire logic [WAIT_W-1:0]        wait_interval,
   input  wire qst_type                  q_st,
   input  wire eng_status_type           eng_st,
   output logic                          push,
   output msg_type                       push_data
);

   localparam logic [31:0] FLOWS_L = 32'(FLOWS);

   logic [TIME_W-1:0] now_ff;
   logic [TIME_W-1:0] now_in;
   logic              accept;

   function automatic logic [IDX_MAX_W-1:0] flow_index(input logic [FLOW_W-1:0] f);
      logic [FLOW_W-1:0] rem;
      logic [31:0]       step;
      rem = f;
      if (FLOWS_L < 32'd256) begin
         for (int i = FLOW_W - 1; i >= 0; i--) begin
            step = FLOWS_L << i;
            if (32'(rem) >= step) begin
               rem = rem - step[FLOW_W-1:0];
            end
         end
      end
      return IDX_MAX_W'(rem);
   endfunction

   assign req_stall = q_st.full || eng_st.clearing;
   assign accept    = req_valid && !req_stall;
   assign push      = accept && (req_action == ACT_MESSAGE);

   always_comb begin
      push_data.idx          = flow_index(req_flow);
      push_data.has_seq      = req_has_seq;
      push_data.seq          = req_seq;
      push_data.cause_reset  = req_cause_reset;
      push_data.now          = now_ff;
      push_data.new_deadline = now_ff + TIME_W'(wait_interval);
   end

   always_comb begin
      now_in = now_ff;
      if (accept && (req_action == ACT_TICK)) begin
         now_in = now_ff + TIME_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff <= '0;
      end else begin
         now_ff <= now_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/psc_queue.sv
// Two-entry transaction queue between the front end and the engine.
// Uses psc_pkg.
`default_nettype none

module psc_queue
   import psc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire msg_type push_data,
   input  wire logic    pop,
   output msg_type      head,
   output qst_type      q_st
);

   msg_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign head       = entry_ff[rd_ptr_ff];
   assign q_st.full  = (count_ff == 2'd2);
   assign q_st.empty = (count_ff == 2'd0);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/psc_engine.sv
// Back end of the sequence checker: per-flow table, clearing pass, table
// read-modify-write and result register. Uses psc_pkg.
`default_nettype none

module psc_engine
   import psc_pkg::*;
#(
   parameter int FLOWS = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire msg_type           q_head,
   input  wire qst_type           q_st,
   output logic                   pop,
   output eng_status_type         eng_st,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_accepted,
   output logic                   rsp_entry_known,
   output logic [SEQ_W-1:0]       rsp_current_seq
);

   localparam int IDX_W = $clog2(FLOWS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOWS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   state_type         state_ff;
   state_type         state_in;
   logic [IDX_W-1:0]  clr_ff;
   logic [IDX_W-1:0]  clr_in;
   msg_type           item_ff;
   msg_type           item_in;

   logic [1:0]        flag_mem [FLOWS];
   logic [SEQ_W-1:0]  seq_mem  [FLOWS];
   logic [TIME_W-1:0] dl_mem   [FLOWS];
   logic [1:0]        flags_rd_ff;
   logic [SEQ_W-1:0]  seq_rd_ff;
   logic [TIME_W-1:0] dl_rd_ff;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_idx;
   logic [IDX_W-1:0]  wr_idx;
   logic              flag_we;
   logic [1:0]        flag_wdata;
   logic              seq_we;
   logic              dl_we;

   logic              known_r;
   logic              waiting_r;
   logic              known_n;
   logic              waiting_n;
   logic [SEQ_W-1:0]  seq_n;
   logic [SEQ_W-1:0]  expect_seq;
   logic              seq_set;
   logic              dl_set;
   logic              ok;

   logic              out_free;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_acc_ff;
   logic              rsp_known_ff;
   logic [SEQ_W-1:0]  rsp_seq_ff;
   logic              rsp_load;

   assign known_r   = flags_rd_ff[1];
   assign waiting_r = flags_rd_ff[0];
   assign rd_idx    = q_head.idx[IDX_W-1:0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign eng_st.clearing = (state_ff == ST_CLEAR);

   // decide the transaction from the table entry
   always_comb begin
      known_n    = known_r;
      waiting_n  = waiting_r;
      seq_n      = seq_rd_ff;
      seq_set    = 1'b0;
      dl_set     = 1'b0;
      ok         = 1'b0;
      expect_seq = SEQ_UNKNOWN;
      priority if (!item_ff.has_seq) begin
         ok = 1'b0;
      end else if (item_ff.cause_reset) begin
         known_n   = 1'b1;
         waiting_n = 1'b0;
         seq_n     = item_ff.seq;
         seq_set   = 1'b1;
         ok        = 1'b1;
      end else if (waiting_r) begin
         if (deadline_ahead(dl_rd_ff, item_ff.now)) begin
            ok = 1'b1;
         end else begin
            dl_set = 1'b1;
         end
      end else begin
         if (known_r) begin
            seq_n      = seq_rd_ff + SEQ_W'(1);
            seq_set    = 1'b1;
            expect_seq = seq_n;
         end
         if (expect_seq != item_ff.seq) begin
            waiting_n = 1'b1;
            dl_set    = 1'b1;
         end else begin
            ok = 1'b1;
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      item_in    = item_ff;
      pop        = 1'b0;
      rd_en      = 1'b0;
      flag_we    = 1'b0;
      flag_wdata = 2'b00;
      seq_we     = 1'b0;
      dl_we      = 1'b0;
      wr_idx     = item_ff.idx[IDX_W-1:0];
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            flag_we = 1'b1;
            wr_idx  = clr_ff;
            clr_in  = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_st.empty) begin
               pop      = 1'b1;
               rd_en    = 1'b1;
               item_in  = q_head;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               flag_we    = 1'b1;
               flag_wdata = {known_n, waiting_n};
               seq_we     = seq_set;
               dl_we      = dl_set;
               rsp_load   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (rsp_load) begin
         rsp_acc_ff   <= ok;
         rsp_known_ff <= known_n;
         rsp_seq_ff   <= known_n ? seq_n : SEQ_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[wr_idx] <= flag_wdata;
      end
      if (seq_we) begin
         seq_mem[wr_idx] <= seq_n;
      end
      if (dl_we) begin
         dl_mem[wr_idx] <= item_ff.new_deadline;
      end
      if (rd_en) begin
         flags_rd_ff <= flag_mem[rd_idx];
         seq_rd_ff   <= seq_mem[rd_idx];
         dl_rd_ff    <= dl_mem[rd_idx];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_acc_ff;
   assign rsp_entry_known = rsp_known_ff;
   assign rsp_current_seq = rsp_seq_ff;

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_st.empty)
      else $error("pop from empty queue");

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !pop)
      else $error("pop during clearing pass");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("result raised outside execute");

   a_hold_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) && rsp_valid_ff && rsp_stall |=> (state_ff == ST_EXEC))
      else $error("result overwritten while stalled");

endmodule

`default_nettype wire

>>> rtl/per_flow_sequence_checker.sv
// Top level of the per-flow sequence checker: wait interval register, front
// end, transaction queue and engine. Uses psc_pkg, psc_front, psc_queue, psc_engine.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  action, flow, has_seq, seq_value, cause_reset
//   rsp      out        rsp_valid/rsp_stall  accepted, entry_known, current_seq
//   csr      in         csr_wr_en            csr_wr_data (wait interval)
//
// A message transaction takes one table read, then one update that waits
// while rsp_stall holds the result; a tick is handled in the front end and
// never reaches the engine. After reset a clearing pass over FLOWS table rows
// runs with req_stall high; csr writes are taken throughout.
// The two-entry queue lets the front end accept while the engine waits on
// rsp_stall; req_stall rises when the queue is full.
`default_nettype none

module per_flow_sequence_checker
   import psc_pkg::*;
#(
   parameter int FLOWS = 256
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_action,
   input  wire logic [FLOW_W-1:0]       req_flow,
   input  wire logic                    req_has_seq,
   input  wire logic signed [SEQ_W-1:0] req_seq_value,
   input  wire logic                    req_cause_reset,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic                         rsp_accepted,
   output logic                         rsp_entry_known,
   output logic signed [SEQ_W-1:0]      rsp_current_seq,
   input  wire logic                    csr_wr_en,
   input  wire logic [WAIT_W-1:0]       csr_wr_data
);

   logic [WAIT_W-1:0] wait_interval_ff;
   logic [WAIT_W-1:0] wait_interval_in;
   logic              push;
   msg_type           push_data;
   logic              pop;
   msg_type           q_head;
   qst_type           q_st;
   eng_status_type    eng_st;
   logic [SEQ_W-1:0]  rsp_seq;

   assign wait_interval_in = csr_wr_en ? csr_wr_data : wait_interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_interval_ff <= WAIT_RESET;
      end else begin
         wait_interval_ff <= wait_interval_in;
      end
   end

   psc_front #(
      .FLOWS (FLOWS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_flow        (req_flow),
      .req_has_seq     (req_has_seq),
      .req_seq         ($unsigned(req_seq_value)),
      .req_cause_reset (req_cause_reset),
      .wait_interval   (wait_interval_ff),
      .q_st            (q_st),
      .eng_st          (eng_st),
      .push            (push),
      .push_data       (push_data)
   );

   psc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (q_head),
      .q_st      (q_st)
   );

   psc_engine #(
      .FLOWS (FLOWS)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .q_head          (q_head),
      .q_st            (q_st),
      .pop             (pop),
      .eng_st          (eng_st),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accepted    (rsp_accepted),
      .rsp_entry_known (rsp_entry_known),
      .rsp_current_seq (rsp_seq)
   );

   assign rsp_current_seq = $signed(rsp_seq);

endmodule

`default_nettype wire

>>> tb/tb_per_flow_sequence_checker.sv
// Testbench for per_flow_sequence_checker: directed and random transactions
// checked against an in-bench flow table predictor held in a small scoreboard.
// Depends on psc_pkg and the per_flow_sequence_checker RTL.
`timescale 1ns / 1ps

module tb_per_flow_sequence_checker
   import psc_pkg::*;
;

   localparam int NUM_FLOWS        = 256;
   localparam int LIMIT_CYCLES     = 400000;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int NUM_PHASES       = 7;

   typedef struct packed {
      logic             action;
      logic [FLOW_W-1:0] flow;
      logic             has_seq;
      logic [SEQ_W-1:0] seq;
      logic             cause_reset;
   } req_item_type;

   typedef struct packed {
      logic             accepted;
      logic             entry_known;
      logic [SEQ_W-1:0] current_seq;
   } verdict_type;

   class seq_scoreboard;
      bit               flow_known[NUM_FLOWS];
      bit [SEQ_W-1:0]   flow_seq[NUM_FLOWS];
      bit               flow_waiting[NUM_FLOWS];
      bit [TIME_W-1:0]  flow_deadline[NUM_FLOWS];
      bit [TIME_W-1:0]  now_ticks;
      bit [WAIT_W-1:0]  wait_interval;
      verdict_type      verdict_q[$];
      int               errors;

      function new();
         foreach (flow_known[i]) begin
            flow_known[i]   = 1'b0;
            flow_waiting[i] = 1'b0;
         end
         now_ticks     = '0;
         wait_interval = WAIT_RESET;
         errors        = 0;
      endfunction

      function int pending();
         return verdict_q.size();
      endfunction

      function void note_item(req_item_type it);
         int unsigned    f;
         verdict_type    v;
         bit [SEQ_W-1:0] want;
         if (it.action == ACT_TICK) begin
            now_ticks = now_ticks + 1;
            return;
         end
         f = it.flow % NUM_FLOWS;
         v.accepted = 1'b0;
         if (!it.has_seq) begin
            v.accepted = 1'b0;
         end else if (it.cause_reset) begin
            flow_known[f]   = 1'b1;
            flow_seq[f]     = it.seq;
            flow_waiting[f] = 1'b0;
            v.accepted      = 1'b1;
         end else if (flow_waiting[f]) begin
            if ($signed(flow_deadline[f] - now_ticks) > 0) begin
               v.accepted = 1'b1;
            end else begin
               flow_deadline[f] = now_ticks + wait_interval;
            end
         end else begin
            want = '1;
            if (flow_known[f]) begin
               flow_seq[f] = flow_seq[f] + 1;
               want = flow_seq[f];
            end
            if (want != it.seq) begin
               flow_waiting[f]  = 1'b1;
               flow_deadline[f] = now_ticks + wait_interval;
            end else begin
               v.accepted = 1'b1;
            end
         end
         v.entry_known = flow_known[f];
         v.current_seq = flow_known[f] ? flow_seq[f] : '1;
         verdict_q.push_back(v);
      endfunction

      task flag_mismatch(string what);
         $display("[%0t] MISMATCH %s", $realtime, what);
         errors++;
      endtask

      task check_result(logic accepted, logic entry_known, logic [SEQ_W-1:0] current_seq);
         verdict_type v;
         if (verdict_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected result acc=%0b known=%0b seq=%h",
                                    accepted, entry_known, current_seq));
            return;
         end
         v = verdict_q.pop_front();
         if (accepted !== v.accepted)
            flag_mismatch($sformatf("accepted got %b want %b", accepted, v.accepted));
         if (entry_known !== v.entry_known)
            flag_mismatch($sformatf("entry_known got %b want %b", entry_known, v.entry_known));
         if (current_seq !== v.current_seq)
            flag_mismatch($sformatf("current_seq got %h want %h", current_seq, v.current_seq));
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_action = ACT_MESSAGE;
   logic [FLOW_W-1:0]       req_flow = '0;
   logic                    req_has_seq = 1'b0;
   logic signed [SEQ_W-1:0] req_seq_value = '0;
   logic                    req_cause_reset = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_accepted;
   logic                    rsp_entry_known;
   logic signed [SEQ_W-1:0] rsp_current_seq;
   logic                    csr_wr_en = 1'b0;
   logic [WAIT_W-1:0]       csr_wr_data = '0;

   seq_scoreboard sb;
   bit            steady = 1'b0;
   bit            long_hold_req = 1'b0;
   int            cycle_count = 0;
   logic [FLOW_W-1:0] hot_flows[6] = '{8'd0, 8'd1, 8'd7, 8'd64, 8'd200, 8'd255};
   logic [WAIT_W-1:0] phase_wait[NUM_PHASES];

   per_flow_sequence_checker #(.FLOWS(NUM_FLOWS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_flow        (req_flow),
      .req_has_seq     (req_has_seq),
      .req_seq_value   (req_seq_value),
      .req_cause_reset (req_cause_reset),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accepted    (rsp_accepted),
      .rsp_entry_known (rsp_entry_known),
      .rsp_current_seq (rsp_current_seq),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         sb.check_result(rsp_accepted, rsp_entry_known, rsp_current_seq);
   end

   // hold off the receiver on request, otherwise stall at random except in steady phases
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_req = 1'b0;
         end
         rsp_stall <= !steady && ($urandom_range(99) < 16);
      end
   end

   function automatic req_item_type message_item(logic [FLOW_W-1:0] flow, logic has_seq,
                                                 logic [SEQ_W-1:0] seq, logic cause_reset);
      req_item_type it;
      it.action      = ACT_MESSAGE;
      it.flow        = flow;
      it.has_seq     = has_seq;
      it.seq         = seq;
      it.cause_reset = cause_reset;
      return it;
   endfunction

   function automatic req_item_type tick_item();
      req_item_type it;
      it = message_item(8'($urandom), 1'($urandom), $urandom, 1'($urandom));
      it.action = ACT_TICK;
      return it;
   endfunction

   function automatic logic [SEQ_W-1:0] edge_seq();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // mostly well-formed sequences on a few busy flows, with noise
   function automatic req_item_type make_item();
      logic [FLOW_W-1:0] flow;
      logic [SEQ_W-1:0]  next_seq;
      int unsigned       roll;
      if ($urandom_range(99) < 25)
         return tick_item();
      flow = ($urandom_range(99) < 80) ? hot_flows[$urandom_range(0, 5)] : 8'($urandom);
      roll = $urandom_range(99);
      if (roll < 5)
         return message_item(flow, 1'b0, $urandom, 1'($urandom));
      if (roll < 17)
         return message_item(flow, 1'b1, edge_seq(), 1'b1);
      next_seq = sb.flow_known[flow % NUM_FLOWS] ? sb.flow_seq[flow % NUM_FLOWS] + 1 : '1;
      roll = $urandom_range(99);
      if (roll < 75)
         return message_item(flow, 1'b1, next_seq, 1'b0);
      if (roll < 87)
         return message_item(flow, 1'b1, next_seq + ($urandom_range(0, 1) ? 1 : -1), 1'b0);
      return message_item(flow, 1'b1, edge_seq(), 1'b0);
   endfunction

   task automatic send_item(input req_item_type it);
      while (!steady && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= it.action;
      req_flow        <= it.flow;
      req_has_seq     <= it.has_seq;
      req_seq_value   <= it.seq;
      req_cause_reset <= it.cause_reset;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_item(it);
   endtask

   task automatic drain(input int settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_wait_interval(input logic [WAIT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.wait_interval = value;
   endtask

   task automatic run_random(input int count, input int phase);
      for (int i = 0; i < count; i++) begin
         if (phase == 2 && i == 30)
            long_hold_req = 1'b1;
         if (phase == 2 && i == 110)
            drain(0);
         send_item(make_item());
      end
   endtask

   initial begin
      sb = new();
      phase_wait = '{WAIT_RESET, 24'd1, 24'd0, 24'hFF_FFFF, 24'd3,
                     WAIT_W'($urandom_range(2, 12)), 24'd6};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_item(message_item(8'd0,   1'b0, 32'h1234_5678, 1'b0));
      send_item(message_item(8'd0,   1'b0, 32'h1234_5678, 1'b1));
      send_item(message_item(8'd1,   1'b1, 32'hFFFF_FFFF, 1'b0));
      send_item(message_item(8'd2,   1'b1, 32'h0000_0005, 1'b0));
      send_item(message_item(8'd2,   1'b1, 32'h0000_0009, 1'b0));
      send_item(tick_item());
      send_item(message_item(8'd255, 1'b1, 32'h7FFF_FFFF, 1'b1));
      send_item(message_item(8'd255, 1'b1, 32'h8000_0000, 1'b0));
      send_item(message_item(8'd255, 1'b1, 32'h8000_0000, 1'b0));
      send_item(message_item(8'd3,   1'b1, 32'hFFFF_FFFF, 1'b1));
      send_item(message_item(8'd3,   1'b1, 32'h0000_0000, 1'b0));
      send_item(message_item(8'd3,   1'b1, 32'h0000_0001, 1'b0));
      send_item(message_item(8'd2,   1'b1, 32'h0000_0000, 1'b1));
      send_item(message_item(8'd2,   1'b1, 32'h0000_0001, 1'b0));
      send_item(message_item(8'd128, 1'b1, 32'hAAAA_AAAA, 1'b0));
      send_item(tick_item());
      send_item(message_item(8'd85,  1'b1, 32'h5555_5555, 1'b1));
      run_random(150, 0);

      for (int p = 1; p < NUM_PHASES; p++) begin
         drain(8);
         write_wait_interval(phase_wait[p]);
         steady = (p == 3);
         run_random(160, p);
      end
      steady = 1'b0;

      drain(16);
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
